/* rtl/iems_pkg.sv */
// Shared types, character codes and marker kind codes for the inline
// emphasis marker scanner. No dependencies; every rtl file imports it.
package iems_pkg;

  // default width of the internal byte position counter
  localparam int unsigned POSITION_BITS_DEF = 16;

  // character codes
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // marker kinds, end code is start code plus one
  localparam logic [2:0] KIND_BI_START     = 3'd0;
  localparam logic [2:0] KIND_BI_END       = 3'd1;
  localparam logic [2:0] KIND_BOLD_START   = 3'd2;
  localparam logic [2:0] KIND_BOLD_END     = 3'd3;
  localparam logic [2:0] KIND_ITAL_START   = 3'd4;
  localparam logic [2:0] KIND_ITAL_END     = 3'd5;
  localparam logic [2:0] KIND_STRIKE_START = 3'd6;
  localparam logic [2:0] KIND_STRIKE_END   = 3'd7;

  // one outgoing marker
  typedef struct packed {
    logic        sat;
    logic        last;
    logic [1:0]  len;
    logic [15:0] pos;
    logic [2:0]  kind;
  } iems_res_t;

  // markers produced by one byte, first in position order
  typedef struct packed {
    logic [1:0] num;
    iems_res_t  first;
    iems_res_t  second;
  } iems_push_t;

  // space, tab or newline
  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  // whitespace or NUL
  function automatic logic is_blank(logic [7:0] c);
    return is_ws(c) || (c == CH_NUL);
  endfunction

  // ASCII letter or digit
  function automatic logic is_word(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

/* rtl/inline_emphasis_marker_scanner_core.sv */
// Inline emphasis marker scanner: text bytes in, emphasis markers out.
// A marker passes the input register and the result queue before it leaves.
// Throughput: one byte per cycle while each byte causes at most one marker and the
// output accepts markers; output is one marker per cycle, set by the single result port.
// Reset (rst_ni low, asynchronous) clears all runs, open flags and positions.
module inline_emphasis_marker_scanner_core import iems_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [2:0] marker_kind, [18:3] marker_position,
                                        // [20:19] marker_length, [23:21] zero
  output logic        m_axis_tlast_o,   // last_of_item
  output logic        m_axis_tuser_o    // position_saturated
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       room;
  logic       adv;
  iems_push_t push;
  iems_res_t  res;

  assign adv             = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || adv;

  // input register: take a new request whenever the held one moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  iems_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_byte_q),
    .end_i  (in_last_q),
    .push_o (push)
  );

  iems_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  // pack result fields
  assign m_axis_tdata_o = {3'b000, res.len, res.pos, res.kind};
  assign m_axis_tlast_o = res.last;
  assign m_axis_tuser_o = res.sat;

endmodule

/* rtl/iems_scan.sv */
// Run tracking, open flags and marker decision for one text byte per step.
// Depends on iems_pkg for character codes, kinds and result types.
module iems_scan import iems_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output iems_push_t push_o
);

  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  // open flag slots
  localparam logic [2:0] IDX_BI     = 3'd0;
  localparam logic [2:0] IDX_BOLD   = 3'd1;
  localparam logic [2:0] IDX_STAR   = 3'd2;
  localparam logic [2:0] IDX_UNDER  = 3'd3;
  localparam logic [2:0] IDX_STRIKE = 3'd4;

  typedef struct packed {
    logic                     hit;
    logic [2:0]               kind;
    logic [POSITION_BITS-1:0] pos;
    logic                     over;
    logic [1:0]               len;
    logic [4:0]               opens;
  } dec_t;

  logic [7:0]               bbr_q, bbr_d, bbr_a;
  logic [7:0]               sym_q, sym_d, sym_a;
  logic [2:0]               cnt_q, cnt_d, cnt_a;
  logic [POSITION_BITS-1:0] rbeg_q, rbeg_d, rbeg_a;
  logic [POSITION_BITS-1:0] rend_q, rend_d, rend_a;
  logic                     bov_q, bov_d, bov_a;
  logic                     eov_q, eov_d, eov_a;
  logic [POSITION_BITS-1:0] npos_q, npos_d;
  logic                     pov_q, pov_d;
  logic [4:0]               opens_q, opens_d, opens_a;
  logic                     cont;
  logic                     is_mark;
  dec_t                     dec0, dec1;

  // decide a finished run given the byte that follows it
  function automatic dec_t decide(
    logic [7:0] sym, logic [2:0] cnt, logic [7:0] prev, logic [7:0] nxt,
    logic [POSITION_BITS-1:0] rb, logic rbo, logic [POSITION_BITS-1:0] re, logic reo,
    logic [4:0] opens
  );
    dec_t       r;
    logic       pair_en;
    logic [2:0] idx;
    logic [2:0] base;
    logic [1:0] len;
    logic [7:0] pu;
    r       = '0;
    r.opens = opens;
    pair_en = 1'b0;
    idx     = IDX_BI;
    base    = KIND_BI_START;
    len     = 2'd1;
    pu      = prev;
    if (sym == CH_STAR) begin
      case (cnt)
        3'd1: begin
          pair_en = 1'b1; idx = IDX_STAR; base = KIND_ITAL_START; len = 2'd1;
        end
        3'd2: begin
          pair_en = 1'b1; idx = IDX_BOLD; base = KIND_BOLD_START; len = 2'd2;
        end
        3'd3: begin
          pair_en = 1'b1; idx = IDX_BI; base = KIND_BI_START; len = 2'd3;
        end
        default: pair_en = 1'b0;
      endcase
    end else if ((sym == CH_TILDE) && (cnt == 3'd2)) begin
      pair_en = 1'b1; idx = IDX_STRIKE; base = KIND_STRIKE_START; len = 2'd2;
    end
    // star and tilde runs: token at run start
    if (pair_en) begin
      r.pos  = rb;
      r.over = rbo;
      r.len  = len;
      if (!opens[idx] && !is_blank(nxt)) begin
        r.hit        = 1'b1;
        r.kind       = base;
        r.opens[idx] = 1'b1;
      end else if (opens[idx] && !is_ws(prev)) begin
        r.hit        = 1'b1;
        r.kind       = base + 3'd1;
        r.opens[idx] = 1'b0;
      end
    end
    // odd underscore run: last underscore is the token
    if ((sym == CH_UNDER) && ((cnt == 3'd1) || (cnt == 3'd3))) begin
      pu     = (cnt == 3'd1) ? prev : CH_UNDER;
      r.pos  = re;
      r.over = reo;
      r.len  = 2'd1;
      if (!opens[IDX_UNDER] && !is_word(pu) && !is_blank(nxt)) begin
        r.hit              = 1'b1;
        r.kind             = KIND_ITAL_START;
        r.opens[IDX_UNDER] = 1'b1;
      end else if (opens[IDX_UNDER] && !is_ws(pu) && !is_word(nxt)) begin
        r.hit              = 1'b1;
        r.kind             = KIND_ITAL_END;
        r.opens[IDX_UNDER] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic iems_res_t to_res(dec_t d, logic last);
    iems_res_t r;
    r.kind = d.kind;
    r.pos  = 16'(d.pos);
    r.len  = d.len;
    r.last = last;
    r.sat  = d.over;
    return r;
  endfunction

  // position counter saturates at its top value
  always_comb begin
    if (npos_q == PosMax) begin
      npos_d = PosMax;
      pov_d  = 1'b1;
    end else begin
      npos_d = npos_q + 1'b1;
      pov_d  = pov_q;
    end
  end

  // extend or decide the current run on the incoming byte
  always_comb begin
    cont    = (cnt_q != 3'd0) && (byte_i == sym_q);
    is_mark = (byte_i == CH_STAR) || (byte_i == CH_TILDE) || (byte_i == CH_UNDER);
    dec0    = decide(sym_q, cnt_q, bbr_q, byte_i, rbeg_q, bov_q, rend_q, eov_q, opens_q);
    bbr_a   = bbr_q;
    sym_a   = sym_q;
    cnt_a   = cnt_q;
    rbeg_a  = rbeg_q;
    bov_a   = bov_q;
    rend_a  = rend_q;
    eov_a   = eov_q;
    opens_a = opens_q;
    if (cont) begin
      dec0.hit = 1'b0;
      if (cnt_q < 3'd4) begin
        cnt_a = cnt_q + 3'd1;
      end else if (sym_q == CH_UNDER) begin
        cnt_a = 3'd3;
      end else begin
        cnt_a = 3'd4;
      end
      rend_a = npos_q;
      eov_a  = pov_q;
    end else begin
      if (cnt_q != 3'd0) begin
        opens_a = dec0.opens;
      end else begin
        dec0.hit = 1'b0;
      end
      if (is_mark) begin
        bbr_a  = (cnt_q != 3'd0) ? sym_q : bbr_q;
        sym_a  = byte_i;
        cnt_a  = 3'd1;
        rbeg_a = npos_q;
        bov_a  = pov_q;
        rend_a = npos_q;
        eov_a  = pov_q;
      end else begin
        bbr_a = byte_i;
        cnt_a = 3'd0;
      end
    end
    // end of text decides the pending run against a newline
    dec1 = decide(sym_a, cnt_a, bbr_a, CH_NL, rbeg_a, bov_a, rend_a, eov_a, opens_a);
    if (!(end_i && (cnt_a != 3'd0))) begin
      dec1.hit = 1'b0;
    end
  end

  // next state: clear everything after the last byte of a text
  always_comb begin
    bbr_d   = bbr_a;
    sym_d   = sym_a;
    cnt_d   = cnt_a;
    rbeg_d  = rbeg_a;
    bov_d   = bov_a;
    rend_d  = rend_a;
    eov_d   = eov_a;
    opens_d = opens_a;
    if (end_i) begin
      bbr_d   = CH_NL;
      sym_d   = CH_NUL;
      cnt_d   = 3'd0;
      rbeg_d  = '0;
      bov_d   = 1'b0;
      rend_d  = '0;
      eov_d   = 1'b0;
      opens_d = '0;
    end
  end

  // order the markers of this byte and flag the final one
  always_comb begin
    push_o = '0;
    if (dec0.hit && dec1.hit) begin
      push_o.num    = 2'd2;
      push_o.first  = to_res(dec0, 1'b0);
      push_o.second = to_res(dec1, 1'b1);
    end else if (dec0.hit) begin
      push_o.num   = 2'd1;
      push_o.first = to_res(dec0, 1'b1);
    end else if (dec1.hit) begin
      push_o.num   = 2'd1;
      push_o.first = to_res(dec1, 1'b1);
    end
    if (!step_i) begin
      push_o.num = 2'd0;
    end
  end

  // hold scanner state, advance on each byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bbr_q   <= CH_NL;
      sym_q   <= CH_NUL;
      cnt_q   <= 3'd0;
      rbeg_q  <= '0;
      bov_q   <= 1'b0;
      rend_q  <= '0;
      eov_q   <= 1'b0;
      npos_q  <= '0;
      pov_q   <= 1'b0;
      opens_q <= '0;
    end else if (step_i) begin
      bbr_q   <= bbr_d;
      sym_q   <= sym_d;
      cnt_q   <= cnt_d;
      rbeg_q  <= rbeg_d;
      bov_q   <= bov_d;
      rend_q  <= rend_d;
      eov_q   <= eov_d;
      opens_q <= opens_d;
      if (end_i) begin
        npos_q <= '0;
        pov_q  <= 1'b0;
      end else begin
        npos_q <= npos_d;
        pov_q  <= pov_d;
      end
    end
  end

endmodule

/* rtl/iems_outq.sv */
// Four-entry result queue that takes up to two markers per cycle.
// Depends on iems_pkg for the result types.
module iems_outq import iems_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  iems_push_t push_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output iems_res_t  res_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  iems_res_t         mem_q [Depth];
  logic [PtrW-1:0]   head_q, tail_q;
  logic [CntW-1:0]   cnt_q;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign res_o   = mem_q[head_q];
  // two free slots after this cycle's pop
  assign room_o  = (cnt_q <= CntW'(Depth - 2)) || ((cnt_q == CntW'(Depth - 1)) && pop);

  // store pushed markers
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[tail_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[tail_q + PtrW'(1)] <= push_i.second;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (pop) begin
        head_q <= head_q + PtrW'(1);
      end
      tail_q <= tail_q + PtrW'(push_i.num);
      cnt_q  <= cnt_q + CntW'(push_i.num) - CntW'(pop);
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue count exceeds depth");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (4'(cnt_q) + 4'(push_i.num) - 4'(pop)) <= 4'(Depth))
    else $error("markers pushed into a full queue");

  a_pop_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (push_i.num == 2'd0)) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("queue count did not drop after a request left");

endmodule
